FILE: hdl/elg_pkg.sv
// ----------------------------------------------------------------------------
// elg_pkg
// Shared widths, codes, state types and the request/response structs of the
// modular multiplier used by the ElGamal unit.
// ----------------------------------------------------------------------------
package elg_pkg;

  // modulus and operand width
  localparam int W     = 32;
  localparam int CNT_W = $clog2(W);
  localparam int IDX_W = 2;

  // operation codes on the kind field
  localparam logic KIND_ENC = 1'b0;
  localparam logic KIND_DEC = 1'b1;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_PRIME = 2'd0;
  localparam logic [IDX_W-1:0] REG_GEN   = 2'd1;
  localparam logic [IDX_W-1:0] REG_KEY   = 2'd2;

  // sequencer states: one per multiplier operation, plus idle and result
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KEY_RED,
    ST_BASE_RED,
    ST_RES_MUL,
    ST_BASE_SQR,
    ST_FIN_MUL,
    ST_OUT
  } state_t;

  // which exponentiation is in progress
  typedef enum logic [1:0] {
    JOB_PUB,
    JOB_C1,
    JOB_EK,
    JOB_DEC
  } job_t;

  // multiplier request: (a * b) mod m, a below m
  typedef struct packed {
    logic         start;
    logic [W-1:0] a;
    logic [W-1:0] b;
    logic [W-1:0] m;
  } mm_req_t;

  typedef struct packed {
    logic         done;
    logic         busy;
    logic [W-1:0] res;
  } mm_rsp_t;

endpackage

FILE: hdl/elgamal_encrypt_decrypt_top.sv
// ----------------------------------------------------------------------------
// elgamal_encrypt_decrypt_top
// ElGamal encrypt/decrypt unit over a configured prime, generator and key.
// ----------------------------------------------------------------------------
// Usage:
//   Configuration: write prime (index 0), generator (1) and private key (2)
//   through cfg_write/cfg_index/cfg_data while the unit is idle. Reset loads
//   prime 23, generator 5, key 6. Unused indexes are ignored.
//   Input channel: in_valid/in_stall; a request is taken when in_valid is
//   high and in_stall low. kind 0 encrypts message with nonce, kind 1
//   decrypts cipher_first/cipher_second and compares with expected_message.
//   Output channel: out_valid/out_stall; one result per request, held
//   steady while out_stall is high. in_stall stays high from acceptance
//   until the result has been taken, so one request is in flight at a time.
// Operation:
//   Everything runs on one bit-serial modular multiplier, one operation at
//   a time. An exponentiation with an n-bit exponent costs one reduction
//   plus up to 2n multiplications. Encrypt runs three exponentiations and a
//   final multiply; decrypt runs a key reduction (skipped for a prime of
//   one), one exponentiation and a multiply. A zero prime gives the result
//   without any multiplier operation. Synchronous reset returns the
//   sequencer to idle.
// ----------------------------------------------------------------------------
module elgamal_encrypt_decrypt_top import elg_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [W-1:0]     cfg_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             kind,
  input  logic [W-1:0]     message,
  input  logic [W-1:0]     nonce,
  input  logic [W-1:0]     cipher_first,
  input  logic [W-1:0]     cipher_second,
  input  logic [W-1:0]     expected_message,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [W-1:0]     public_key,
  output logic [W-1:0]     out_first,
  output logic [W-1:0]     out_second,
  output logic [W-1:0]     recovered,
  output logic             matches_res
);

  logic [W-1:0] prime;
  logic [W-1:0] gen;
  logic [W-1:0] key;
  mm_req_t      mm_req;
  mm_rsp_t      mm_rsp;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      prime <= W'(23);
      gen   <= W'(5);
      key   <= W'(6);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_PRIME: prime <= cfg_data;
        REG_GEN:   gen   <= cfg_data;
        REG_KEY:   key   <= cfg_data;
        default:   prime <= prime;
      endcase
    end
  end

  elg_seq u_seq (
    .clk              (clk),
    .rst              (rst),
    .prime            (prime),
    .gen              (gen),
    .key              (key),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .kind             (kind),
    .message          (message),
    .nonce            (nonce),
    .cipher_first     (cipher_first),
    .cipher_second    (cipher_second),
    .expected_message (expected_message),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .public_key       (public_key),
    .out_first        (out_first),
    .out_second       (out_second),
    .recovered        (recovered),
    .matches_res      (matches_res),
    .mm_req           (mm_req),
    .mm_rsp           (mm_rsp)
  );

  elg_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mm_req),
    .rsp (mm_rsp)
  );

  // busy from acceptance onwards
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted but unit not busy");

  // a pending result blocks new requests
  a_out_blocks_in: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("new request possible while result pending");

  // a match flag only comes with a decrypt result
  a_match_decrypt_only: assert property (@(posedge clk) disable iff (rst)
    (out_valid && matches_res) |->
      (public_key == '0 && out_first == '0 && out_second == '0))
    else $error("match flag set on an encrypt result");

  // multiplier never started while busy
  a_mul_no_restart: assert property (@(posedge clk) disable iff (rst)
    mm_req.start |-> !mm_rsp.busy)
    else $error("multiplier started while busy");

endmodule

FILE: hdl/elg_mul.sv
// ----------------------------------------------------------------------------
// elg_mul
// Bit-serial modular multiplier: scans b from the MSB, one bit per cycle,
// acc = (2*acc + bit*a) mod m. Also used as a plain reducer with a = 1 mod m.
// ----------------------------------------------------------------------------
module elg_mul import elg_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  mm_req_t req,
  output mm_rsp_t rsp
);

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [W-1:0]     acc;
  logic [W-1:0]     a_r;
  logic [W-1:0]     b_r;
  logic [W-1:0]     m_r;

  logic [W+1:0]     t;
  logic [W+2:0]     d1;
  logic [W+2:0]     d2;
  logic [W-1:0]     acc_step;

  // double, add, then take off m or 2m (sum stays below 3m)
  always_comb begin
    t  = {1'b0, acc, 1'b0} + (b_r[W-1] ? {2'b00, a_r} : '0);
    d1 = {1'b0, t} - {3'b000, m_r};
    d2 = {1'b0, t} - {2'b00, m_r, 1'b0};
    if (!d2[W+2]) begin
      acc_step = d2[W-1:0];
    end else if (!d1[W+2]) begin
      acc_step = d1[W-1:0];
    end else begin
      acc_step = t[W-1:0];
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  // operands and accumulator
  always_ff @(posedge clk) begin
    if (req.start && !busy) begin
      acc <= '0;
      a_r <= req.a;
      b_r <= req.b;
      m_r <= req.m;
    end else if (busy) begin
      acc <= acc_step;
      b_r <= {b_r[W-2:0], 1'b0};
    end
  end

  assign rsp.done = done;
  assign rsp.busy = busy;
  assign rsp.res  = acc;

endmodule

FILE: hdl/elg_seq.sv
// ----------------------------------------------------------------------------
// elg_seq
// Sequencer: captures a request, runs right-to-left square-and-multiply
// exponentiations on the shared multiplier and holds the result.
// ----------------------------------------------------------------------------
module elg_seq import elg_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic [W-1:0] prime,
  input  logic [W-1:0] gen,
  input  logic [W-1:0] key,
  input  logic         in_valid,
  output logic         in_stall,
  input  logic         kind,
  input  logic [W-1:0] message,
  input  logic [W-1:0] nonce,
  input  logic [W-1:0] cipher_first,
  input  logic [W-1:0] cipher_second,
  input  logic [W-1:0] expected_message,
  output logic         out_valid,
  input  logic         out_stall,
  output logic [W-1:0] public_key,
  output logic [W-1:0] out_first,
  output logic [W-1:0] out_second,
  output logic [W-1:0] recovered,
  output logic         matches_res,
  output mm_req_t      mm_req,
  input  mm_rsp_t      mm_rsp
);

  state_t       state, state_next;
  job_t         job, job_next;
  logic         pend, pend_next;
  logic         kind_r, kind_r_next;
  logic [W-1:0] ex, ex_next;
  logic [W-1:0] base, base_next;
  logic [W-1:0] powres, powres_next;
  logic [W-1:0] tval, tval_next;
  logic [W-1:0] fin_r, fin_r_next;
  logic [W-1:0] nonce_r, nonce_r_next;
  logic [W-1:0] exp_r, exp_r_next;
  logic [W-1:0] pub_r, pub_r_next;
  logic [W-1:0] first_r, first_r_next;
  logic [W-1:0] second_r, second_r_next;
  logic [W-1:0] rec_r, rec_r_next;
  logic         match_r, match_r_next;

  logic         accept;
  logic         op_state;
  logic [W-1:0] one_p;
  logic [W-1:0] one_pm1;
  logic         pow_end;
  logic [W-1:0] pow_val;

  assign accept  = (state == ST_IDLE) && in_valid;
  assign one_p   = (prime == W'(1)) ? '0 : W'(1);
  assign one_pm1 = (prime == W'(2)) ? '0 : W'(1);
  assign op_state = (state != ST_IDLE) && (state != ST_OUT);

  // end of an exponentiation and its value
  always_comb begin
    pow_end = 1'b0;
    pow_val = mm_rsp.res;
    if (mm_rsp.done) begin
      unique case (state)
        ST_BASE_RED: begin
          if (mm_rsp.res == '0) begin
            pow_end = 1'b1;
            pow_val = '0;
          end else if (ex == '0) begin
            pow_end = 1'b1;
            pow_val = one_p;
          end
        end
        ST_RES_MUL: pow_end = (ex[W-1:1] == '0);
        default:    pow_end = 1'b0;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (prime == '0) begin
            state_next = ST_OUT;
          end else if (kind == KIND_DEC && prime != W'(1)) begin
            state_next = ST_KEY_RED;
          end else begin
            state_next = ST_BASE_RED;
          end
        end
      end
      ST_KEY_RED: begin
        if (mm_rsp.done) state_next = ST_BASE_RED;
      end
      ST_BASE_RED, ST_RES_MUL, ST_BASE_SQR: begin
        if (mm_rsp.done) begin
          if (pow_end) begin
            if (job == JOB_EK || job == JOB_DEC) begin
              state_next = ST_FIN_MUL;
            end else begin
              state_next = ST_BASE_RED;
            end
          end else if (state == ST_RES_MUL) begin
            state_next = ST_BASE_SQR;
          end else begin
            state_next = ex[0] ? ST_RES_MUL : ST_BASE_SQR;
          end
        end
      end
      ST_FIN_MUL: begin
        if (mm_rsp.done) state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!out_stall) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs: handshake and multiplier request
  always_comb begin
    in_stall     = (state != ST_IDLE);
    out_valid    = (state == ST_OUT);
    mm_req.start = op_state && !pend;
    mm_req.a     = one_p;
    mm_req.b     = base;
    mm_req.m     = prime;
    unique case (state)
      ST_KEY_RED: begin
        mm_req.a = one_pm1;
        mm_req.b = key;
        mm_req.m = prime - W'(1);
      end
      ST_RES_MUL: mm_req.a = powres;
      ST_BASE_SQR: mm_req.a = base;
      ST_FIN_MUL: begin
        mm_req.a = tval;
        mm_req.b = fin_r;
      end
      default: mm_req.a = one_p;
    endcase
  end

  // datapath
  always_comb begin
    job_next      = job;
    pend_next     = pend;
    kind_r_next   = kind_r;
    ex_next       = ex;
    base_next     = base;
    powres_next   = powres;
    tval_next     = tval;
    fin_r_next    = fin_r;
    nonce_r_next  = nonce_r;
    exp_r_next    = exp_r;
    pub_r_next    = pub_r;
    first_r_next  = first_r;
    second_r_next = second_r;
    rec_r_next    = rec_r;
    match_r_next  = match_r;

    // one multiplier operation outstanding at a time
    if (mm_req.start) pend_next = 1'b1;
    if (mm_rsp.done)  pend_next = 1'b0;

    if (accept) begin
      kind_r_next   = kind;
      pub_r_next    = '0;
      first_r_next  = '0;
      second_r_next = '0;
      rec_r_next    = '0;
      match_r_next  = (kind == KIND_DEC) && (prime == '0) && (expected_message == '0);
      nonce_r_next  = nonce;
      exp_r_next    = expected_message;
      if (kind == KIND_ENC) begin
        job_next   = JOB_PUB;
        base_next  = gen;
        ex_next    = key;
        fin_r_next = message;
      end else begin
        job_next   = JOB_DEC;
        base_next  = cipher_first;
        ex_next    = '0;
        fin_r_next = cipher_second;
      end
    end

    if (mm_rsp.done) begin
      unique case (state)
        ST_KEY_RED: ex_next = prime - W'(1) - mm_rsp.res;
        ST_BASE_RED: begin
          base_next   = mm_rsp.res;
          powres_next = one_p;
          if (!ex[0]) ex_next = ex >> 1;
        end
        ST_RES_MUL: begin
          powres_next = mm_rsp.res;
          ex_next     = ex >> 1;
        end
        ST_BASE_SQR: begin
          base_next = mm_rsp.res;
          if (!ex[0]) ex_next = ex >> 1;
        end
        ST_FIN_MUL: begin
          if (kind_r == KIND_ENC) begin
            second_r_next = mm_rsp.res;
          end else begin
            rec_r_next   = mm_rsp.res;
            match_r_next = (mm_rsp.res == exp_r);
          end
        end
        default: pend_next = 1'b0;
      endcase
    end

    // hand the finished power on to the next step of the item
    if (pow_end) begin
      unique case (job)
        JOB_PUB: begin
          pub_r_next = pow_val;
          job_next   = JOB_C1;
          base_next  = gen;
          ex_next    = nonce_r;
        end
        JOB_C1: begin
          first_r_next = pow_val;
          job_next     = JOB_EK;
          base_next    = pub_r;
          ex_next      = nonce_r;
        end
        default: tval_next = pow_val;
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= pend_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    job      <= job_next;
    kind_r   <= kind_r_next;
    ex       <= ex_next;
    base     <= base_next;
    powres   <= powres_next;
    tval     <= tval_next;
    fin_r    <= fin_r_next;
    nonce_r  <= nonce_r_next;
    exp_r    <= exp_r_next;
    pub_r    <= pub_r_next;
    first_r  <= first_r_next;
    second_r <= second_r_next;
    rec_r    <= rec_r_next;
    match_r  <= match_r_next;
  end

  assign public_key  = pub_r;
  assign out_first   = first_r;
  assign out_second  = second_r;
  assign recovered   = rec_r;
  assign matches_res = match_r;

endmodule

FILE: verif/elgamal_encrypt_decrypt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elgamal_encrypt_decrypt_checker
// Passive checker for the ElGamal unit. It tracks the configuration writes
// and predicts the reply to every accepted request. It then compares each
// accepted reply, field by field, against the oldest prediction still
// waiting. It hands back a mismatch count and the number of outstanding
// predictions.
// ----------------------------------------------------------------------------
module elgamal_encrypt_decrypt_checker import elg_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [W-1:0]     cfg_data,
  input  logic             in_valid,
  input  logic             in_stall,
  input  logic             kind,
  input  logic [W-1:0]     message,
  input  logic [W-1:0]     nonce,
  input  logic [W-1:0]     cipher_first,
  input  logic [W-1:0]     cipher_second,
  input  logic [W-1:0]     expected_message,
  input  logic             out_valid,
  input  logic             out_stall,
  input  logic [W-1:0]     public_key,
  input  logic [W-1:0]     out_first,
  input  logic [W-1:0]     out_second,
  input  logic [W-1:0]     recovered,
  input  logic             matches_res,
  output int               mismatches,
  output int               outstanding
);

  typedef struct packed {
    logic [W-1:0] public_key;
    logic [W-1:0] first;
    logic [W-1:0] second;
    logic [W-1:0] recovered;
    logic         matched;
  } reply_t;

  // shadow copies of the configuration registers
  logic [W-1:0] prime_reg;
  logic [W-1:0] gen_reg;
  logic [W-1:0] key_reg;

  reply_t pending_replies[$];
  reply_t want;

  // (x * y) mod m, m nonzero; operands reduced first so the product fits
  function automatic logic [63:0] mod_mul(logic [63:0] x, logic [63:0] y, logic [63:0] m);
    return ((x % m) * (y % m)) % m;
  endfunction

  // square and multiply; a base of zero mod m gives zero for any exponent
  function automatic logic [63:0] mod_pow(logic [63:0] base, logic [63:0] ex, logic [63:0] m);
    logic [63:0] b;
    logic [63:0] r;
    logic [63:0] e;
    if (m == 0) return 64'd0;
    b = base % m;
    if (b == 0) return 64'd0;
    r = 64'd1 % m;
    e = ex;
    while (e != 0) begin
      if (e[0]) r = mod_mul(r, b, m);
      e = e >> 1;
      b = mod_mul(b, b, m);
    end
    return r;
  endfunction

  // reply to one request under the current register values
  function automatic reply_t elgamal_predict(logic op, logic [W-1:0] plain, logic [W-1:0] k,
                                             logic [W-1:0] c1, logic [W-1:0] c2,
                                             logic [W-1:0] want_plain);
    reply_t      r;
    logic [63:0] p;
    logic [63:0] e;
    logic [63:0] t;
    logic [63:0] dec_exp;
    logic [63:0] rec;
    p = 64'(prime_reg);
    r = '0;
    if (op == KIND_ENC) begin
      e = mod_pow(64'(gen_reg), 64'(key_reg), p);
      r.public_key = e[W-1:0];
      t = mod_pow(64'(gen_reg), 64'(k), p);
      r.first = t[W-1:0];
      if (p != 0) begin
        t = mod_mul(64'(plain), mod_pow(e, 64'(k), p), p);
        r.second = t[W-1:0];
      end
    end else begin
      rec = 64'd0;
      if (p != 0) begin
        // key folded below p-1 so an oversized key still decrypts
        dec_exp = p - 64'd1 - ((p > 1) ? (64'(key_reg) % (p - 64'd1)) : 64'd0);
        rec = mod_mul(64'(c2), mod_pow(64'(c1), dec_exp, p), p);
      end
      r.recovered = rec[W-1:0];
      r.matched = (rec == 64'(want_plain));
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [W-1:0] exp_val,
                             input logic [W-1:0] got_val);
    if (exp_val !== got_val) begin
      mismatches++;
      $display("%0t: %s expected %h, got %h", $time, name, exp_val, got_val);
    end
  endtask

  // reply check, request prediction, register tracking
  always @(posedge clk) begin
    if (rst) begin
      prime_reg = 32'd23;
      gen_reg = 32'd5;
      key_reg = 32'd6;
      mismatches = 0;
      pending_replies.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_replies.size() == 0) begin
          mismatches++;
          $display("%0t: reply with no request outstanding", $time);
        end else begin
          want = pending_replies.pop_front();
          check_field("public_key", want.public_key, public_key);
          check_field("out_first", want.first, out_first);
          check_field("out_second", want.second, out_second);
          check_field("recovered", want.recovered, recovered);
          check_field("matches_res", {31'd0, want.matched}, {31'd0, matches_res});
        end
      end
      if (in_valid && !in_stall)
        pending_replies.push_back(elgamal_predict(kind, message, nonce, cipher_first,
                                                  cipher_second, expected_message));
      if (cfg_write) begin
        case (cfg_index)
          REG_PRIME: prime_reg = cfg_data;
          REG_GEN:   gen_reg = cfg_data;
          REG_KEY:   key_reg = cfg_data;
          default: ;
        endcase
      end
    end
    outstanding = pending_replies.size();
  end

endmodule

FILE: verif/elgamal_encrypt_decrypt_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elgamal_encrypt_decrypt_top_tb
// Drives the ElGamal unit through directed corner requests and then random
// phases under several prime/generator/key settings and idling patterns.
// Ciphertexts returned by the unit are fed back as decrypt requests.
// Checking is done by the checker instance; this module makes the stimulus
// and gives the verdict.
// ----------------------------------------------------------------------------
module elgamal_encrypt_decrypt_top_tb;
  import elg_pkg::*;

  localparam int CYCLE_LIMIT   = 5_000_000;
  localparam int HOLD_CYCLES   = 12_000;
  localparam int SETTLE_CYCLES = 8;
  localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct {
    logic         kind;
    logic [W-1:0] plain;
  } sent_t;

  typedef struct {
    logic [W-1:0] first;
    logic [W-1:0] second;
    logic [W-1:0] plain;
  } cipher_t;

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_write;
  logic [IDX_W-1:0] cfg_index;
  logic [W-1:0]     cfg_data;
  logic             in_valid;
  logic             in_stall;
  logic             kind;
  logic [W-1:0]     message;
  logic [W-1:0]     nonce;
  logic [W-1:0]     cipher_first;
  logic [W-1:0]     cipher_second;
  logic [W-1:0]     expected_message;
  logic             out_valid;
  logic             out_stall;
  logic [W-1:0]     public_key;
  logic [W-1:0]     out_first;
  logic [W-1:0]     out_second;
  logic [W-1:0]     recovered;
  logic             matches_res;

  int           mismatches;
  int           outstanding;
  int           send_idle_pct = 0;
  int           stall_pct = 0;
  int           hold_left = 0;
  logic         hold_request = 1'b0;
  int           cycle_count = 0;
  logic [W-1:0] cur_prime = 32'd23;
  sent_t        in_flight_q[$];
  cipher_t      cipher_q[$];
  sent_t        done_req;

  elgamal_encrypt_decrypt_top u_top (.*);

  elgamal_encrypt_decrypt_checker u_checker (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("elgamal_encrypt_decrypt_top_tb: done, errors");
      $finish;
    end
  end

  // receiver: random stalls, or a long hold-off when requested
  always @(negedge clk) begin
    if (hold_request) begin
      hold_left = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // keep returned ciphertexts so they can be sent back for decryption
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall && in_flight_q.size() > 0) begin
      done_req = in_flight_q.pop_front();
      if (done_req.kind == KIND_ENC)
        cipher_q.push_back('{out_first, out_second, done_req.plain});
    end
  end

  // offer one request, with a random idle gap first; returns on a falling edge
  task automatic send_req(input logic op, input logic [W-1:0] m, input logic [W-1:0] k,
                          input logic [W-1:0] c1, input logic [W-1:0] c2,
                          input logic [W-1:0] want_plain);
    sent_t rec;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    kind <= op;
    message <= m;
    nonce <= k;
    cipher_first <= c1;
    cipher_second <= c2;
    expected_message <= want_plain;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    rec.kind = op;
    rec.plain = (cur_prime != 0) ? m % cur_prime : m;
    in_flight_q.push_back(rec);
    @(negedge clk);
  endtask

  // stop offering and wait for every reply, then let the unit settle
  task automatic drain();
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // write all registers while idle, the unused index included
  task automatic set_config(input logic [W-1:0] p, input logic [W-1:0] g,
                            input logic [W-1:0] a);
    drain();
    cfg_write <= 1'b1;
    cfg_index <= REG_PRIME;
    cfg_data <= p;
    @(negedge clk);
    cfg_index <= REG_GEN;
    cfg_data <= g;
    @(negedge clk);
    cfg_index <= REG_KEY;
    cfg_data <= a;
    @(negedge clk);
    cfg_index <= REG_SPARE;
    cfg_data <= $urandom;
    @(negedge clk);
    cfg_write <= 1'b0;
    cur_prime = p;
    cipher_q.delete();
  endtask

  // mostly round trips and encrypts, the rest noise decrypts
  task automatic random_req();
    int           pick;
    cipher_t      ct;
    logic [W-1:0] plain;
    pick = $urandom_range(99);
    if (cipher_q.size() > 0 && pick < 45) begin
      ct = cipher_q.pop_front();
      send_req(KIND_DEC, $urandom, $urandom, ct.first, ct.second,
               (pick < 36) ? ct.plain : ct.plain ^ ($urandom | 32'd1));
    end else if (pick < 85) begin
      plain = ($urandom_range(3) == 0 || cur_prime == 0) ? $urandom : $urandom % cur_prime;
      send_req(KIND_ENC, plain, $urandom >> $urandom_range(31, 0),
               $urandom, $urandom, $urandom);
    end else begin
      send_req(KIND_DEC, $urandom, $urandom, ($urandom_range(7) == 0) ? '0 : $urandom,
               $urandom, $urandom);
    end
  endtask

  task automatic random_phase(input logic [W-1:0] p, input logic [W-1:0] g,
                              input logic [W-1:0] a, input int count, input int idle,
                              input int stall, input bit pressure);
    set_config(p, g, a);
    send_idle_pct = idle;
    stall_pct = stall;
    if (pressure) hold_request = 1'b1;
    for (int i = 0; i < count; i++) begin
      // halfway through, let everything outstanding come back first
      if (pressure && i == count / 2) drain();
      random_req();
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    kind = KIND_ENC;
    message = '0;
    nonce = '0;
    cipher_first = '0;
    cipher_second = '0;
    expected_message = '0;
    out_stall = 1'b0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset registers: prime 23, generator 5, key 6
    send_req(KIND_ENC, '0, '0, $urandom, $urandom, $urandom);
    send_req(KIND_ENC, '1, '1, $urandom, $urandom, $urandom);
    send_req(KIND_ENC, 32'd22, 32'd1, $urandom, $urandom, $urandom);
    send_req(KIND_ENC, 32'd23, 32'd5, $urandom, $urandom, $urandom);
    send_req(KIND_DEC, $urandom, $urandom, '0, 32'd9, '0);
    send_req(KIND_DEC, $urandom, $urandom, 32'd23, 32'd7, '0);
    send_req(KIND_DEC, $urandom, $urandom, '1, '1, '1);
    send_req(KIND_DEC, $urandom, $urandom, 32'd1, '0, '0);
    // a known round trip: 10 encrypts to (10, 14)
    send_req(KIND_ENC, 32'd10, 32'd3, $urandom, $urandom, $urandom);
    send_req(KIND_DEC, $urandom, $urandom, 32'd10, 32'd14, 32'd10);

    // modulus zero
    set_config('0, 32'd5, 32'd6);
    send_req(KIND_ENC, $urandom, $urandom, $urandom, $urandom, $urandom);
    send_req(KIND_DEC, $urandom, $urandom, $urandom, $urandom, '0);
    // modulus one
    set_config(32'd1, 32'd5, 32'd6);
    send_req(KIND_ENC, $urandom, $urandom, $urandom, $urandom, $urandom);
    send_req(KIND_DEC, $urandom, $urandom, $urandom, $urandom, '0);
    // key equal to p-1, then key far above it
    set_config(32'd23, 32'd5, 32'd22);
    send_req(KIND_ENC, 32'd7, 32'd4, $urandom, $urandom, $urandom);
    send_req(KIND_DEC, $urandom, $urandom, 32'd10, 32'd14, 32'd14);
    set_config(32'd23, 32'd5, '1);
    send_req(KIND_ENC, 32'd7, 32'd4, $urandom, $urandom, $urandom);
    send_req(KIND_DEC, $urandom, $urandom, 32'd10, 32'd14, 32'd10);
    // generator congruent to zero, zero nonce
    set_config(32'd23, 32'd23, 32'd6);
    send_req(KIND_ENC, 32'd5, '0, $urandom, $urandom, $urandom);

    random_phase(32'd4294967291, 32'd2, $urandom, 15, 0, 0, 1'b0);
    random_phase(32'd65521, 32'd17, 32'd65519, 15, 69, 0, 1'b0);
    random_phase(32'd2147483647, '1, 32'd1, 15, 0, 69, 1'b0);
    random_phase(32'd7, 32'd3, $urandom_range(5, 1), 15, 38, 38, 1'b0);
    random_phase(32'd1000000007, 32'd5, $urandom, 15, 0, 0, 1'b1);
    random_phase(32'd3, 32'd2, 32'd1, 10, 38, 38, 1'b0);
    random_phase('1, 32'd3, 32'hFFFF_FFFD, 15, 0, 69, 1'b0);

    drain();
    if (mismatches == 0 && outstanding == 0)
      $display("elgamal_encrypt_decrypt_top_tb: done, clean");
    else
      $display("elgamal_encrypt_decrypt_top_tb: done, errors");
    $finish;
  end

endmodule
